@@ design/fixed_point_arith_unit_macros.svh @@
// assertion macros shared by the fixed point arithmetic unit
`ifndef FIXED_POINT_ARITH_UNIT_MACROS_SVH
`define FIXED_POINT_ARITH_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FPAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FPAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/fpau_pkg.sv @@
// shared types and codes for the fixed point arithmetic unit
package fpau_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DataW   = 32;
  localparam int unsigned MagW    = 64;

  localparam logic [CmdW-1:0] CMD_MUL   = 3'd0;
  localparam logic [CmdW-1:0] CMD_DIV   = 3'd1;
  localparam logic [CmdW-1:0] CMD_ROUND = 3'd2;
  localparam logic [CmdW-1:0] CMD_CEIL  = 3'd3;
  localparam logic [CmdW-1:0] CMD_FLOOR = 3'd4;

  localparam logic [StatusW-1:0] STATUS_OK   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_SAT  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_DIVZ = 2'd2;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic            valid;
    logic [CmdW-1:0] cmd;
    logic            neg;
  } ctrl_t;

endpackage

@@ design/fpau_front.sv @@
// first stage: operand magnitudes, signs and the round/ceil/floor magnitudes
module fpau_front #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [fpau_pkg::CmdW-1:0]             cmd_i,
  input  logic signed [fpau_pkg::DataW-1:0]     a_i,
  input  logic signed [fpau_pkg::DataW-1:0]     b_i,
  output fpau_pkg::ctrl_t                       ctrl_o,
  output logic [fpau_pkg::DataW-1:0]            abs_a_o,
  output logic [fpau_pkg::DataW-1:0]            abs_b_o,
  output logic [fpau_pkg::MagW-1:0]             mag_o
);
  import fpau_pkg::*;

  localparam logic [DataW:0] Half     = (DataW+1)'(1) << (FRACTION_BITS - 1);
  localparam logic [DataW:0] FracMask = ((DataW+1)'(1) << FRACTION_BITS) - (DataW+1)'(1);
  localparam logic [DataW:0] Bias     = (DataW+1)'(1) << (DataW - 1);

  ctrl_t              ctrl_d, ctrl_q;
  logic [DataW-1:0]   abs_a_d, abs_b_d, abs_a_q, abs_b_q;
  logic [MagW-1:0]    mag_d, mag_q;
  logic               sign_a, sign_b;
  logic [DataW:0]     rnd_sum, rnd_mag;
  logic [DataW:0]     u_base, u_up, u_clr, cf_mag;
  logic               cf_pos;

  // magnitudes and signs
  always_comb begin
    sign_a  = a_i[DataW-1];
    sign_b  = b_i[DataW-1];
    abs_a_d = sign_a ? (DataW'(0) - a_i) : a_i;
    abs_b_d = sign_b ? (DataW'(0) - b_i) : b_i;
  end

  // round half away from zero on the magnitude
  always_comb begin
    rnd_sum = {1'b0, abs_a_d} + Half;
    rnd_mag = rnd_sum & ~FracMask;
  end

  // ceil and floor on a biased, non-negative copy of a
  always_comb begin
    u_base = {1'b0, ~a_i[DataW-1], a_i[DataW-2:0]};
    u_up   = (cmd_i == CMD_CEIL) ? (u_base + FracMask) : u_base;
    u_clr  = u_up & ~FracMask;
    cf_pos = (u_clr >= Bias);
    cf_mag = cf_pos ? (u_clr - Bias) : (Bias - u_clr);
  end

  // per-command sign and magnitude
  always_comb begin
    ctrl_d.valid = valid_i;
    ctrl_d.cmd   = cmd_i;
    ctrl_d.neg   = 1'b0;
    mag_d        = '0;
    case (cmd_i) inside
      CMD_MUL, CMD_DIV: ctrl_d.neg = sign_a ^ sign_b;
      CMD_ROUND: begin
        ctrl_d.neg = sign_a;
        mag_d      = MagW'(rnd_mag);
      end
      CMD_CEIL, CMD_FLOOR: begin
        ctrl_d.neg = ~cf_pos;
        mag_d      = MagW'(cf_mag);
      end
      default: ctrl_d.neg = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_a_q <= abs_a_d;
      abs_b_q <= abs_b_d;
      mag_q   <= mag_d;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign abs_a_o = abs_a_q;
  assign abs_b_o = abs_b_q;
  assign mag_o   = mag_q;

endmodule

@@ design/fpau_mult.sv @@
// second stage: magnitude product and divider operand setup
module fpau_mult #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  fpau_pkg::ctrl_t                             ctrl_i,
  input  logic [fpau_pkg::DataW-1:0]                  abs_a_i,
  input  logic [fpau_pkg::DataW-1:0]                  abs_b_i,
  input  logic [fpau_pkg::MagW-1:0]                   mag_i,
  output fpau_pkg::ctrl_t                             ctrl_o,
  output logic [fpau_pkg::DataW+FRACTION_BITS-1:0]    num_o,
  output logic [fpau_pkg::DataW-1:0]                  den_o,
  output logic [fpau_pkg::MagW-1:0]                   mag_o
);
  import fpau_pkg::*;

  localparam int unsigned NumW = DataW + FRACTION_BITS;

  ctrl_t            ctrl_q;
  logic [NumW-1:0]  num_q;
  logic [DataW-1:0] den_q;
  logic [MagW-1:0]  mag_d, mag_q;

  // unsigned 32x32 product for multiply, pass-through otherwise
  always_comb begin
    if (ctrl_i.cmd == CMD_MUL) begin
      mag_d = MagW'(abs_a_i) * MagW'(abs_b_i);
    end else begin
      mag_d = mag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= {abs_a_i, FRACTION_BITS'(0)};
      den_q <= abs_b_i;
      mag_q <= mag_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign num_o  = num_q;
  assign den_o  = den_q;
  assign mag_o  = mag_q;

endmodule

@@ design/fpau_div_stage.sv @@
// one restoring divide step: one quotient bit per stage
module fpau_div_stage #(
  parameter int unsigned NUM_W = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  fpau_pkg::ctrl_t                   ctrl_i,
  input  logic [NUM_W-1:0]                  num_i,
  input  logic [fpau_pkg::DataW-1:0]        rem_i,
  input  logic [fpau_pkg::DataW-1:0]        den_i,
  input  logic [fpau_pkg::MagW-1:0]         mag_i,
  output fpau_pkg::ctrl_t                   ctrl_o,
  output logic [NUM_W-1:0]                  num_o,
  output logic [fpau_pkg::DataW-1:0]        rem_o,
  output logic [fpau_pkg::DataW-1:0]        den_o,
  output logic [fpau_pkg::MagW-1:0]         mag_o
);
  import fpau_pkg::*;

  ctrl_t            ctrl_q;
  logic [NUM_W-1:0] num_d, num_q;
  logic [DataW-1:0] rem_d, rem_q, den_q;
  logic [MagW-1:0]  mag_q;
  logic [DataW:0]   shifted, diff;
  logic             fits;

  // shift in the next numerator bit and try the subtract
  always_comb begin
    shifted = {rem_i, num_i[NUM_W-1]};
    fits    = (shifted >= {1'b0, den_i});
    diff    = shifted - {1'b0, den_i};
    rem_d   = fits ? diff[DataW-1:0] : shifted[DataW-1:0];
    num_d   = {num_i[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
      den_q <= den_i;
      mag_q <= mag_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign num_o  = num_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign mag_o  = mag_q;

endmodule

@@ design/fpau_final.sv @@
// last stage: rounding, saturation and the output register
`include "fixed_point_arith_unit_macros.svh"

module fpau_final #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        stall_i,
  input  fpau_pkg::ctrl_t                             ctrl_i,
  input  logic [fpau_pkg::DataW+FRACTION_BITS-1:0]    quot_i,
  input  logic [fpau_pkg::DataW-1:0]                  rem_i,
  input  logic [fpau_pkg::DataW-1:0]                  den_i,
  input  logic [fpau_pkg::MagW-1:0]                   mag_i,
  output logic                                        valid_o,
  output logic signed [fpau_pkg::DataW-1:0]           result_o,
  output logic [fpau_pkg::StatusW-1:0]                status_o
);
  import fpau_pkg::*;

  localparam logic [MagW:0]   Half   = (MagW+1)'(1) << (FRACTION_BITS - 1);
  localparam logic [MagW-1:0] PosMax = MagW'(32'h7FFF_FFFF);
  localparam logic [MagW-1:0] NegMax = MagW'(32'h8000_0000);

  logic               valid_q;
  logic [DataW-1:0]   result_d, result_q;
  logic [StatusW-1:0] status_d, status_q;
  logic [MagW:0]      mul_sum;
  logic [MagW-1:0]    mag_full;
  logic               rnd_up;

  // final magnitude per command
  always_comb begin
    mul_sum  = {1'b0, mag_i} + Half;
    rnd_up   = ({rem_i, 1'b0} >= {1'b0, den_i});
    case (ctrl_i.cmd)
      CMD_MUL: mag_full = MagW'(mul_sum >> FRACTION_BITS);
      CMD_DIV: mag_full = MagW'(quot_i) + MagW'(rnd_up);
      default: mag_full = mag_i;
    endcase
  end

  // saturate to the signed word and pick the status
  always_comb begin
    result_d = '0;
    status_d = STATUS_OK;
    if (ctrl_i.cmd > CMD_FLOOR) begin
      result_d = '0;
      status_d = STATUS_OK;
    end else if ((ctrl_i.cmd == CMD_DIV) && (den_i == '0)) begin
      result_d = '0;
      status_d = STATUS_DIVZ;
    end else if (!ctrl_i.neg) begin
      if (mag_full > PosMax) begin
        result_d = PosMax[DataW-1:0];
        status_d = STATUS_SAT;
      end else begin
        result_d = mag_full[DataW-1:0];
      end
    end else begin
      if (mag_full > NegMax) begin
        result_d = NegMax[DataW-1:0];
        status_d = STATUS_SAT;
      end else begin
        result_d = DataW'(0) - mag_full[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign status_o = status_q;

  `FPAU_ASSERT_NEXT(a_hold_valid, valid_q && stall_i, valid_q, "held result dropped")
  `FPAU_ASSERT_NOW(a_divz_zero, valid_q && (status_q == STATUS_DIVZ), result_q == '0,
                   "divide by zero result not zero")
  `FPAU_ASSERT_NOW(a_sat_limit, valid_q && (status_q == STATUS_SAT),
                   (result_q == 32'h7FFF_FFFF) || (result_q == 32'h8000_0000),
                   "saturated result not at a limit")
  `FPAU_ASSERT_NOW(a_status_code, valid_q, status_q != 2'd3, "unknown status code")

endmodule

@@ design/fixed_point_arith_unit.sv @@
// Signed fixed-point multiply, divide, round, ceil and floor unit. Each transfer in yields one
// result transfer out through a pipeline of one stage for magnitudes and round/ceil/floor,
// one for the 32x32 product, one restoring divide step per quotient bit (32+FRACTION_BITS
// stages), and the rounding/saturation output stage. A new item is taken every cycle, except
// that the whole pipeline holds while a result waits on a stall, and only then.
module fixed_point_arith_unit #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [fpau_pkg::CmdW-1:0]             command_i,
  input  logic signed [fpau_pkg::DataW-1:0]     operand_a_i,
  input  logic signed [fpau_pkg::DataW-1:0]     operand_b_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [fpau_pkg::DataW-1:0]     result_value_o,
  output logic [fpau_pkg::StatusW-1:0]          status_code_o
);
  import fpau_pkg::*;

  localparam int unsigned NumW = DataW + FRACTION_BITS;

  logic             en;
  ctrl_t            front_ctrl;
  logic [DataW-1:0] front_abs_a, front_abs_b;
  logic [MagW-1:0]  front_mag;

  ctrl_t            ctrl_s [NumW+1];
  logic [NumW-1:0]  num_s  [NumW+1];
  logic [DataW-1:0] rem_s  [NumW+1];
  logic [DataW-1:0] den_s  [NumW+1];
  logic [MagW-1:0]  mag_s  [NumW+1];

  // whole pipeline advances unless a finished result is stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  fpau_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cmd_i   (command_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .ctrl_o  (front_ctrl),
    .abs_a_o (front_abs_a),
    .abs_b_o (front_abs_b),
    .mag_o   (front_mag)
  );

  fpau_mult #(.FRACTION_BITS(FRACTION_BITS)) u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctrl_i  (front_ctrl),
    .abs_a_i (front_abs_a),
    .abs_b_i (front_abs_b),
    .mag_i   (front_mag),
    .ctrl_o  (ctrl_s[0]),
    .num_o   (num_s[0]),
    .den_o   (den_s[0]),
    .mag_o   (mag_s[0])
  );

  // remainder starts at zero
  assign rem_s[0] = '0;

  // divider chain
  for (genvar i = 0; i < NumW; i++) begin : g_div
    fpau_div_stage #(.NUM_W(NumW)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[i]),
      .num_i  (num_s[i]),
      .rem_i  (rem_s[i]),
      .den_i  (den_s[i]),
      .mag_i  (mag_s[i]),
      .ctrl_o (ctrl_s[i+1]),
      .num_o  (num_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .den_o  (den_s[i+1]),
      .mag_o  (mag_s[i+1])
    );
  end

  fpau_final #(.FRACTION_BITS(FRACTION_BITS)) u_final (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .stall_i  (out_stall_i),
    .ctrl_i   (ctrl_s[NumW]),
    .quot_i   (num_s[NumW]),
    .rem_i    (rem_s[NumW]),
    .den_i    (den_s[NumW]),
    .mag_i    (mag_s[NumW]),
    .valid_o  (out_valid_o),
    .result_o (result_value_o),
    .status_o (status_code_o)
  );

endmodule

@@ tb/tb_fixed_point_arith_unit.sv @@
// self-checking testbench for the fixed point arithmetic unit
`timescale 1ns / 1ps

module tb_fixed_point_arith_unit;
  import fpau_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned Latency    = FracBits + 35;
  localparam int unsigned RandItems  = 800;

  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [DataW-1:0]   a;
    logic [DataW-1:0]   b;
    bit                 has_exp;
    logic [DataW-1:0]   exp_value;
    logic [StatusW-1:0] exp_status;
  } stim_row_t;

  typedef struct {
    logic [DataW-1:0]   value;
    logic [StatusW-1:0] status;
  } fx_result_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [CmdW-1:0]            command_i;
  logic signed [DataW-1:0]    operand_a_i;
  logic signed [DataW-1:0]    operand_b_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [DataW-1:0]    result_value_o;
  logic [StatusW-1:0]         status_code_o;

  fx_result_t pending_results[$];
  int         mismatch_count;
  int         sent_count;
  int         recv_count;
  bit         quiet_phase;
  bit         hold_recv;
  bit         stim_done;

  fixed_point_arith_unit #(.FRACTION_BITS(FracBits)) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .operand_a_i    (operand_a_i),
    .operand_b_i    (operand_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_code_o  (status_code_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // sign and magnitude to saturated word
  function automatic fx_result_t pack_signed(bit neg, logic [63:0] mag);
    fx_result_t r;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) begin
        r.value = 32'h7FFF_FFFF; r.status = STATUS_SAT;
      end else begin
        r.value = mag[31:0]; r.status = STATUS_OK;
      end
    end else begin
      if (mag > 64'h8000_0000) begin
        r.value = 32'h8000_0000; r.status = STATUS_SAT;
      end else begin
        r.value = 32'(-mag); r.status = STATUS_OK;
      end
    end
    return r;
  endfunction

  // fixed point arithmetic result for one command
  function automatic fx_result_t fixed_point_result(logic [CmdW-1:0] cmd,
                                                    logic [DataW-1:0] a_bits,
                                                    logic [DataW-1:0] b_bits);
    fx_result_t r;
    longint signed a, b, prod;
    logic [63:0] mag_a, mag_b, m, num, q, rem, u;
    logic [63:0] one_unit, half_unit, frac_mask, bias;
    one_unit  = 64'd1 << FracBits;
    half_unit = 64'd1 << (FracBits - 1);
    frac_mask = one_unit - 1;
    bias      = 64'h8000_0000;
    a = longint'($signed(a_bits));
    b = longint'($signed(b_bits));
    mag_a = (a < 0) ? 64'(-a) : 64'(a);
    mag_b = (b < 0) ? 64'(-b) : 64'(b);
    r.value = '0;
    r.status = STATUS_OK;
    case (cmd) inside
      CMD_MUL: begin
        prod = a * b;
        m = (((prod < 0) ? 64'(-prod) : 64'(prod)) + half_unit) >> FracBits;
        r = pack_signed(prod < 0, m);
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.value = '0; r.status = STATUS_DIVZ;
        end else begin
          num = mag_a << FracBits;
          q = num / mag_b;
          rem = num % mag_b;
          if (2 * rem >= mag_b) q++;
          r = pack_signed((a < 0) != (b < 0), q);
        end
      end
      CMD_ROUND: begin
        m = ((mag_a + half_unit) >> FracBits) << FracBits;
        r = pack_signed(a < 0, m);
      end
      CMD_CEIL, CMD_FLOOR: begin
        u = 64'(a + longint'(bias));
        if (cmd == CMD_CEIL) u += frac_mask;
        u &= ~frac_mask;
        if (u >= bias) r = pack_signed(1'b0, u - bias);
        else r = pack_signed(1'b1, bias - u);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, recv_count);
    mismatch_count++;
  endtask

  // offer one item and wait for its transfer
  task automatic send_item(logic [CmdW-1:0] cmd, logic [DataW-1:0] a, logic [DataW-1:0] b,
                           bit has_exp, logic [DataW-1:0] ev, logic [StatusW-1:0] es);
    fx_result_t r;
    if (!quiet_phase) begin
      while ($urandom_range(99) < 34) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = fixed_point_result(cmd, a, b);
    if (has_exp && (r.value !== ev || r.status !== es))
      report_mismatch("directed row vs predictor", {r.value, 30'd0, r.status},
                      {ev, 30'd0, es});
    if (has_exp) begin
      r.value = ev; r.status = es;
    end
    pending_results.push_back(r);
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [DataW-1:0] random_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
      1: return $urandom_range(15) << FracBits;
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      3: return ($urandom_range(7) << FracBits) | (32'h1 << (FracBits - 1));
      default: return $urandom();
    endcase
  endfunction

  // stimulus: directed table, then random items with pressure phases
  initial begin
    stim_row_t rows[$];
    logic [CmdW-1:0] cmd;
    logic [DataW-1:0] b;
    rows = '{
      '{CMD_MUL,   32'h0001_0000, 32'h0001_0000, 1, 32'h0001_0000, STATUS_OK},
      '{CMD_MUL,   32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, STATUS_SAT},
      '{CMD_MUL,   32'h8000_0000, 32'h7FFF_FFFF, 1, 32'h8000_0000, STATUS_SAT},
      '{CMD_MUL,   32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, STATUS_SAT},
      '{CMD_MUL,   32'h0000_0001, 32'h0000_8000, 1, 32'h0000_0001, STATUS_OK},
      '{CMD_MUL,   32'hFFFF_FFFF, 32'h0000_8000, 1, 32'hFFFF_FFFF, STATUS_OK},
      '{CMD_MUL,   32'h8000_0000, 32'h0001_0000, 1, 32'h8000_0000, STATUS_OK},
      '{CMD_DIV,   32'h0001_0000, 32'h0000_0000, 1, 32'h0000_0000, STATUS_DIVZ},
      '{CMD_DIV,   32'h8000_0000, 32'h0000_0000, 1, 32'h0000_0000, STATUS_DIVZ},
      '{CMD_DIV,   32'h0001_0000, 32'h0002_0000, 1, 32'h0000_8000, STATUS_OK},
      '{CMD_DIV,   32'h7FFF_FFFF, 32'h0000_0001, 1, 32'h7FFF_FFFF, STATUS_SAT},
      '{CMD_DIV,   32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, STATUS_SAT},
      '{CMD_DIV,   32'h0000_0001, 32'h0002_0000, 1, 32'h0000_0001, STATUS_OK},
      '{CMD_DIV,   32'h8000_0000, 32'h0001_0000, 1, 32'h8000_0000, STATUS_OK},
      '{CMD_ROUND, 32'h0000_8000, 32'h0,         1, 32'h0001_0000, STATUS_OK},
      '{CMD_ROUND, 32'hFFFF_8000, 32'h0,         1, 32'hFFFF_0000, STATUS_OK},
      '{CMD_ROUND, 32'h7FFF_FFFF, 32'h0,         1, 32'h7FFF_FFFF, STATUS_SAT},
      '{CMD_ROUND, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'h8000_0000, STATUS_OK},
      '{CMD_CEIL,  32'h7FFF_0001, 32'h0,         1, 32'h7FFF_FFFF, STATUS_SAT},
      '{CMD_CEIL,  32'hFFFF_0001, 32'h0,         1, 32'h0000_0000, STATUS_OK},
      '{CMD_FLOOR, 32'h8000_0001, 32'h0,         1, 32'h8000_0000, STATUS_OK},
      '{CMD_FLOOR, 32'h0001_FFFF, 32'h0,         1, 32'h0001_0000, STATUS_OK},
      '{3'd5,      32'h1234_5678, 32'h1,         1, 32'h0000_0000, STATUS_OK},
      '{3'd6,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0000_0000, STATUS_OK},
      '{3'd7,      32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, STATUS_OK}
    };
    in_valid_i  = 1'b0;
    command_i   = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    quiet_phase = 1'b0;
    hold_recv   = 1'b0;
    stim_done   = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].has_exp,
                rows[i].exp_value, rows[i].exp_status);
    for (int n = 0; n < RandItems; n++) begin
      // long receiver hold while the sender keeps offering
      if (n == 100) hold_recv = 1'b1;
      if (n == 300) quiet_phase = 1'b1;
      if (n == 450) quiet_phase = 1'b0;
      // sender drains the pipeline before going on
      if (n == 500) begin
        in_valid_i <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk_i);
      end
      cmd = (n % 10 == 9) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      b = random_operand();
      if (cmd == CMD_DIV && $urandom_range(15) == 0) b = '0;
      send_item(cmd, random_operand(), b, 1'b0, '0, '0);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall generation, with one long hold counted in cycles
  initial begin
    int hold_cycles;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_recv) begin
        hold_recv = 1'b0;
        out_stall_i <= 1'b1;
        for (hold_cycles = 0; hold_cycles < 3 * Latency; hold_cycles++) @(negedge clk_i);
      end
      out_stall_i <= !quiet_phase && ($urandom_range(99) < 34);
    end
  end

  // result checking
  always @(posedge clk_i) begin
    fx_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 64'(unsigned'(result_value_o)),
                        64'd0);
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value)
          report_mismatch("result_value", 64'(unsigned'(result_value_o)), 64'(want.value));
        if (status_code_o !== want.status)
          report_mismatch("status_code", 64'(status_code_o), 64'(want.status));
      end
      recv_count++;
    end
  end

  // end of run
  initial begin
    mismatch_count = 0;
    sent_count = 0;
    recv_count = 0;
    wait (rst_ni);
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (2 * Latency) @(posedge clk_i);
    if (pending_results.size() != 0) mismatch_count++;
    $display("covered %0d transfers in, %0d out: all commands, saturation, divide by zero,",
             sent_count, recv_count);
    $display("ties, unused codes, long output hold and full drain");
    if (mismatch_count == 0) begin
      $display("tb_fixed_point_arith_unit passed");
    end else begin
      $display("tb_fixed_point_arith_unit failed");
    end
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("tb_fixed_point_arith_unit failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/fpau_pkg.sv
design/fpau_front.sv
design/fpau_mult.sv
design/fpau_div_stage.sv
design/fpau_final.sv
design/fixed_point_arith_unit.sv
tb/tb_fixed_point_arith_unit.sv
